// ===== src/cuckoo_hash_string_insert_defines.svh =====
// Assertion macros shared by the cuckoo hash insert modules.
`ifndef CUCKOO_HASH_STRING_INSERT_DEFINES_SVH
`define CUCKOO_HASH_STRING_INSERT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define CHSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define CHSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/chsi_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package chsi_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_SLOTS     = 17;
  localparam int HASH_MULTIPLIER = 41;
  localparam int ID_BITS         = 16;

  // Fixed field widths on the ports
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 7;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 5;
  localparam int OID_W   = 16;
  localparam int OUT_W   = KIND_W + 1 + SLOT_W + 2 * OID_W;
  localparam int STEP_W  = $clog2(CHAR_W);

  // Reset value of the eviction limit
  localparam int MAX_KICKS_RESET = 34;

  typedef enum logic [KIND_W-1:0] {
    EV_EMPTY = 2'd0,
    EV_EVICT = 2'd1,
    EV_FAIL  = 2'd2
  } event_kind_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              accept;    // load a character, clear step accumulators
    logic              hash_step; // one bit of the serial modular multiplies
    logic              first;     // step on the sign bit of the character
    logic [STEP_W-1:0] bit_sel;   // bit processed in this step
    logic              fold;      // fold accumulators into the hashes
    logic              ins_start; // take the finished key as the homeless key
    logic              mem_read;  // read the slot at (table, position)
    logic              place;     // write into an empty slot, report
    logic              evict;     // swap with the occupant, report
    logic              fail;      // report failure
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;   // result register full and not taken this cycle
    logic at_limit;   // eviction count reached the limit
    logic slot_valid; // registered valid bit of the slot just read
  } dp_stat_t;

endpackage

// ===== src/chsi_ctrl.sv =====
// Controller state machine: character hashing sequence and cuckoo insert steps.
`timescale 1ns / 1ps
`include "cuckoo_hash_string_insert_defines.svh"
module chsi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  output logic               in_tready,
  input  chsi_pkg::dp_stat_t stat,
  output chsi_pkg::dp_cmd_t  cmd
);
  import chsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_FOLD,
    S_START,
    S_READ,
    S_STEP,
    S_FAIL
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              end_r, end_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    end_nxt   = end_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          end_nxt    = in_tlast;
          cnt_nxt    = '0;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        // bits are taken from the top down
        cmd.hash_step = 1'b1;
        cmd.first     = (cnt_r == '0);
        cmd.bit_sel   = ~cnt_r;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(CHAR_W - 1)) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = end_r ? S_START : S_IDLE;
      end
      S_START: begin
        cmd.ins_start = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        if (stat.at_limit) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_STEP: begin
        if (!stat.out_busy) begin
          if (!stat.slot_valid) begin
            cmd.place = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.evict = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_FAIL: begin
        if (!stat.out_busy) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, bit counter and last-character flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
  end

  `CHSI_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.accept, cmd.hash_step, cmd.fold, cmd.ins_start, cmd.mem_read, cmd.place, cmd.evict, cmd.fail}), "more than one datapath command")
  `CHSI_ASSERT_NOW(a_start_after_fold, cmd.ins_start, $past(cmd.fold), "insertion started without a folded hash")
  `CHSI_ASSERT_NEXT(a_evict_then_read, cmd.evict, state_r == S_READ, "eviction not followed by a slot lookup")

endmodule

// ===== src/chsi_dp.sv =====
// Datapath: serial modular hashing, slot memory, homeless key and result register.
`timescale 1ns / 1ps
`include "cuckoo_hash_string_insert_defines.svh"
module chsi_dp #(
  parameter int TABLE_SLOTS     = chsi_pkg::TABLE_SLOTS,
  parameter int HASH_MULTIPLIER = chsi_pkg::HASH_MULTIPLIER,
  parameter int ID_BITS         = chsi_pkg::ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chsi_pkg::dp_cmd_t             cmd,
  output chsi_pkg::dp_stat_t            stat,
  input  logic [chsi_pkg::CHAR_W-1:0]   key_char,
  input  logic                          cfg_we,
  input  logic [chsi_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output chsi_pkg::event_kind_t         event_kind,
  output logic                          table_sel,
  output logic [chsi_pkg::SLOT_W-1:0]   slot_index,
  output logic [chsi_pkg::OID_W-1:0]    placed_id,
  output logic [chsi_pkg::OID_W-1:0]    evicted_id,
  output logic                          run_last
);
  import chsi_pkg::*;

  localparam int HW        = $clog2(TABLE_SLOTS);
  localparam int AW        = HW + 1;
  localparam int DEPTH     = 2 ** AW;
  localparam int EW        = 2 * HW + ID_BITS;
  localparam int KICK_CAP  = 2 * TABLE_SLOTS;
  localparam int KW        = $clog2(KICK_CAP + 1);
  localparam int LIMIT_RST = (MAX_KICKS_RESET < KICK_CAP) ? MAX_KICKS_RESET : KICK_CAP;
  localparam logic [HW:0]       N_W     = (HW + 1)'(TABLE_SLOTS);
  localparam logic [CHAR_W-1:0] MR_BITS = CHAR_W'(HASH_MULTIPLIER % TABLE_SLOTS);

  // Modular add of two residues
  function automatic logic [HW-1:0] madd(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [HW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= N_W) s = s - N_W;
    return s[HW-1:0];
  endfunction

  // Modular subtract of two residues
  function automatic logic [HW-1:0] msub(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [HW:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + N_W - {1'b0, b};
    return s[HW-1:0];
  endfunction

  // Hash state
  logic [CHAR_W-1:0]  char_r;
  logic [HW-1:0]      hf_r, hr_r, pt_r;
  logic [HW-1:0]      acc_f_r, acc_c_r, acc_hm_r, acc_pm_r;
  logic [ID_BITS-1:0] kid_r;

  // Homeless key and insertion walk
  logic [HW-1:0]      cur_hf_r, cur_hr_r, pos_r;
  logic [ID_BITS-1:0] cur_id_r;
  logic               tbl_r;
  logic [KW-1:0]      kicks_r, limit_r;

  // Slot memory and its valid bits
  logic [EW-1:0]      mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [EW-1:0]      rd_r;
  logic               rd_vld_r;
  logic [AW-1:0]      addr;
  logic [HW-1:0]      rd_hf, rd_hr;
  logic [ID_BITS-1:0] rd_id;

  // Result register
  logic               ovalid_r;
  event_kind_t        kind_r;
  logic               otbl_r, olast_r;
  logic [SLOT_W-1:0]  oslot_r;
  logic [OID_W-1:0]   opid_r, oeid_r;
  logic               emit;

  // One step of the serial multiplies
  logic               cbit, mbit;
  logic [HW-1:0]      d_f, d_c, d_hm, d_pm;
  logic [HW-1:0]      acc_f_nxt, acc_c_nxt, acc_hm_nxt, acc_pm_nxt;

  assign addr = {tbl_r, pos_r};
  assign {rd_hf, rd_hr, rd_id} = rd_r;
  assign emit = cmd.place | cmd.evict | cmd.fail;

  assign cbit = char_r[cmd.bit_sel];
  assign mbit = MR_BITS[cmd.bit_sel];
  assign d_f  = madd(acc_f_r, acc_f_r);
  assign d_c  = madd(acc_c_r, acc_c_r);
  assign d_hm = madd(acc_hm_r, acc_hm_r);
  assign d_pm = madd(acc_pm_r, acc_pm_r);

  // Character is signed: its top bit weighs negative
  always_comb begin
    if (cmd.first && cbit) begin
      acc_f_nxt = msub(d_f, pt_r);
      acc_c_nxt = msub(d_c, HW'(1));
    end else begin
      acc_f_nxt = madd(d_f, cbit ? pt_r : '0);
      acc_c_nxt = madd(d_c, cbit ? HW'(1) : '0);
    end
    acc_hm_nxt = madd(d_hm, mbit ? hr_r : '0);
    acc_pm_nxt = madd(d_pm, mbit ? pt_r : '0);
  end

  // Hashing and key walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hf_r    <= '0;
      hr_r    <= '0;
      pt_r    <= HW'(1);
      kid_r   <= '0;
      kicks_r <= '0;
      limit_r <= KW'(LIMIT_RST);
    end else begin
      if (cfg_we) begin
        if (int'(cfg_data) > KICK_CAP) limit_r <= KW'(KICK_CAP);
        else                           limit_r <= KW'(cfg_data);
      end
      if (cmd.accept) begin
        char_r   <= key_char;
        acc_f_r  <= '0;
        acc_c_r  <= '0;
        acc_hm_r <= '0;
        acc_pm_r <= '0;
      end
      if (cmd.hash_step) begin
        acc_f_r  <= acc_f_nxt;
        acc_c_r  <= acc_c_nxt;
        acc_hm_r <= acc_hm_nxt;
        acc_pm_r <= acc_pm_nxt;
      end
      if (cmd.fold) begin
        hf_r <= madd(hf_r, acc_f_r);
        hr_r <= madd(acc_hm_r, acc_c_r);
        pt_r <= acc_pm_r;
      end
      if (cmd.ins_start) begin
        cur_hf_r <= hf_r;
        cur_hr_r <= hr_r;
        cur_id_r <= kid_r;
        kid_r    <= kid_r + 1'b1;
        hf_r     <= '0;
        hr_r     <= '0;
        pt_r     <= HW'(1);
        tbl_r    <= 1'b0;
        pos_r    <= hf_r;
        kicks_r  <= '0;
      end
      // the evicted key moves on to the other table
      if (cmd.evict) begin
        cur_hf_r <= rd_hf;
        cur_hr_r <= rd_hr;
        cur_id_r <= rd_id;
        tbl_r    <= ~tbl_r;
        pos_r    <= tbl_r ? rd_hf : rd_hr;
        kicks_r  <= kicks_r + 1'b1;
      end
    end
  end

  // Slot memory: one write or one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.place || cmd.evict) mem[addr] <= {cur_hf_r, cur_hr_r, cur_id_r};
    if (cmd.mem_read)           rd_r      <= mem[addr];
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.place)    vld_r[addr] <= 1'b1;
      if (cmd.mem_read) rd_vld_r    <= vld_r[addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      otbl_r  <= tbl_r;
      oslot_r <= SLOT_W'(pos_r);
      opid_r  <= OID_W'(cur_id_r);
      priority if (cmd.place) begin
        kind_r  <= EV_EMPTY;
        oeid_r  <= '0;
        olast_r <= 1'b1;
      end else if (cmd.evict) begin
        kind_r  <= EV_EVICT;
        oeid_r  <= OID_W'(rd_id);
        olast_r <= 1'b0;
      end else begin
        kind_r  <= EV_FAIL;
        oeid_r  <= '0;
        olast_r <= 1'b1;
      end
    end
  end

  assign stat.out_busy   = ovalid_r & ~out_ready;
  assign stat.at_limit   = (kicks_r >= limit_r);
  assign stat.slot_valid = rd_vld_r;

  assign out_valid  = ovalid_r;
  assign event_kind = kind_r;
  assign table_sel  = otbl_r;
  assign slot_index = oslot_r;
  assign placed_id  = opid_r;
  assign evicted_id = oeid_r;
  assign run_last   = olast_r;

  `CHSI_ASSERT_NOW(a_emit_free, emit, !(ovalid_r && !out_ready), "result overwritten before taken")
  `CHSI_ASSERT_NOW(a_pos_range, cmd.mem_read, pos_r < HW'(TABLE_SLOTS - 1) || pos_r == HW'(TABLE_SLOTS - 1), "slot position out of table")
  `CHSI_ASSERT_NEXT(a_kick_bound, cmd.evict, kicks_r <= limit_r, "eviction count passed the limit")

endmodule

// ===== src/cuckoo_hash_string_insert.sv =====
// Top level: stream ports, configuration port and controller/datapath pair.
`timescale 1ns / 1ps
// Cuckoo hash insert of string keys over two tables of TABLE_SLOTS slots each.
// Key characters arrive one item at a time, tlast on the last one. Each
// character is accepted, run through the bit-serial modular multiplies (one
// character bit per cycle) and then folded into the hashes. After the last
// character, insertion starts, then each slot visited is read from memory
// and decided on; a decision waits while the result register waits on
// out_tready. Each visited slot gives one result item and reaching max_kicks
// gives a failure item; tlast on the final one. max_kicks saturates at twice
// the table size. The tables are empty after reset with no clearing pass.
module cuckoo_hash_string_insert #(
  parameter int TABLE_SLOTS     = chsi_pkg::TABLE_SLOTS,
  parameter int HASH_MULTIPLIER = chsi_pkg::HASH_MULTIPLIER,
  parameter int ID_BITS         = chsi_pkg::ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: key_char[7:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tlast,
  // out_tdata: event_kind[1:0], table_sel[2], slot_index[7:3],
  //            placed_id[23:8], evicted_id[39:24]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [chsi_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast,
  // cfg_data: max_kicks
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [chsi_pkg::CFG_W-1:0]  cfg_data
);
  import chsi_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  event_kind_t         event_kind;
  logic                table_sel;
  logic [SLOT_W-1:0]   slot_index;
  logic [OID_W-1:0]    placed_id, evicted_id;

  // The limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  chsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  chsi_dp #(
    .TABLE_SLOTS     (TABLE_SLOTS),
    .HASH_MULTIPLIER (HASH_MULTIPLIER),
    .ID_BITS         (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .key_char   (in_tdata),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .event_kind (event_kind),
    .table_sel  (table_sel),
    .slot_index (slot_index),
    .placed_id  (placed_id),
    .evicted_id (evicted_id),
    .run_last   (out_tlast)
  );

  // Pack result fields, lowest first
  assign out_tdata = {evicted_id, placed_id, slot_index, table_sel, event_kind};

endmodule
